/* sv/rrts_pkg.sv */
package rrts_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int SP_W           = 32;
    localparam int SLOT_FIELD_W   = 6;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 40;

    typedef enum logic {
        OP_CREATE   = 1'b0,
        OP_SCHEDULE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

endpackage

/* sv/rrts_picker.sv */
module rrts_picker #(
    parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_W     = $clog2(SLOT_COUNT)
) (
    input  logic [SLOT_COUNT-1:0] running,
    input  logic [SLOT_W-1:0]     cur_slot,
    output logic                  free_found,
    output logic [SLOT_W-1:0]     free_slot,
    output logic [SLOT_W-1:0]     next_slot
);

    logic [SLOT_COUNT-1:0] above_cur;
    logic                  above_any;
    logic [SLOT_W-1:0]     above_slot;
    logic                  run_any;
    logic [SLOT_W-1:0]     run_slot;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!running[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // running slots strictly after the current one
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            above_cur[i] = running[i] && (i > int'(cur_slot));
        end
    end

    always_comb begin
        above_any  = 1'b0;
        above_slot = '0;
        run_any    = 1'b0;
        run_slot   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (above_cur[i]) begin
                above_any  = 1'b1;
                above_slot = SLOT_W'(i);
            end
            if (running[i]) begin
                run_any  = 1'b1;
                run_slot = SLOT_W'(i);
            end
        end
    end

    // next running slot after the current one, else wrap to the lowest running slot, else keep the current one
    always_comb begin
        if (above_any) begin
            next_slot = above_slot;
        end else if (run_any) begin
            next_slot = run_slot;
        end else begin
            next_slot = cur_slot;
        end
    end

endmodule

/* sv/round_robin_task_switcher_unit.sv */
// Task-slot table with a round-robin context-switch picker. Each input item is
// either a create (s_tuser low), which claims the lowest free slot for the
// stack pointer in s_tdata, or a schedule (s_tuser high), which saves the given
// pointer into the current slot and returns the next running slot after it,
// wrapping round, with that slot's saved pointer. m_tuser high marks success;
// a create with every slot taken, or a schedule before any task exists,
// returns m_tuser low with zero data. Slot pointers sit in a one-port-write,
// one-port-read memory with a registered read; the lowest-free and next-running
// picks are taken when the item is accepted. A create and a schedule both pass
// through an execute state, which updates the table while the pointer memory is
// written and, for a schedule, read, and then a response state, which loads the
// result into the output register once that is free. One item is in work at a
// time, so no item is accepted until the last one has loaded its result; the next
// is accepted while the previous result still waits on m_tready.
module round_robin_task_switcher_unit #(
    parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rrts_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] stack_pointer
    input  logic                           s_tuser,   // [0] operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rrts_pkg::M_TDATA_W-1:0] m_tdata,   // [5:0] slot, [37:6] next_stack_pointer
    output logic                           m_tuser    // [0] ok
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int SP_W   = rrts_pkg::SP_W;
    localparam int SF_W   = rrts_pkg::SLOT_FIELD_W;

    rrts_pkg::state_t state_reg, state_next;

    rrts_pkg::op_t         op_reg;
    logic [SP_W-1:0]       sp_reg;
    logic                  free_found_reg;
    logic [SLOT_W-1:0]     free_slot_reg;
    logic [SLOT_W-1:0]     next_slot_reg;

    logic [SLOT_COUNT-1:0] running_reg, running_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic                  cur_valid_reg, cur_valid_next;

    logic                  res_ok_reg, res_ok_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic                  res_rd_reg, res_rd_next;
    logic                  res_fwd_reg, res_fwd_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_ok_reg;
    logic [SF_W-1:0]       m_slot_reg;
    logic [SP_W-1:0]       m_nsp_reg;

    logic [SP_W-1:0]       ptr_mem [SLOT_COUNT];
    logic [SP_W-1:0]       rd_data_reg;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic                  mem_re;
    logic [SLOT_W-1:0]     mem_raddr;

    logic                  pick_free_found;
    logic [SLOT_W-1:0]     pick_free_slot;
    logic [SLOT_W-1:0]     pick_next_slot;

    logic                  in_fire;
    logic                  out_room;
    logic                  out_load;
    logic [SP_W-1:0]       res_nsp;

    rrts_picker #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_picker (
        .running    (running_reg),
        .cur_slot   (cur_reg),
        .free_found (pick_free_found),
        .free_slot  (pick_free_slot),
        .next_slot  (pick_next_slot)
    );

    assign s_tready = (state_reg == rrts_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_room = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == rrts_pkg::ST_RESP) && out_room;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrts_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = rrts_pkg::ST_EXEC;
                end
            end
            rrts_pkg::ST_EXEC: begin
                state_next = rrts_pkg::ST_RESP;
            end
            rrts_pkg::ST_RESP: begin
                if (out_room) begin
                    state_next = rrts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrts_pkg::ST_IDLE;
            end
        endcase
    end

    // table update and result in the execute step
    always_comb begin
        running_next   = running_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        res_rd_next    = res_rd_reg;
        res_fwd_next   = res_fwd_reg;
        mem_we         = 1'b0;
        mem_waddr      = free_slot_reg;
        mem_re         = 1'b0;
        mem_raddr      = next_slot_reg;
        if (state_reg == rrts_pkg::ST_EXEC) begin
            res_ok_next   = 1'b0;
            res_slot_next = '0;
            res_rd_next   = 1'b0;
            res_fwd_next  = 1'b0;
            if (op_reg == rrts_pkg::OP_CREATE) begin
                if (free_found_reg) begin
                    running_next[free_slot_reg] = 1'b1;
                    mem_we        = 1'b1;
                    mem_waddr     = free_slot_reg;
                    res_ok_next   = 1'b1;
                    res_slot_next = free_slot_reg;
                    if (!cur_valid_reg) begin
                        cur_next       = free_slot_reg;
                        cur_valid_next = 1'b1;
                    end
                end
            end else if (cur_valid_reg) begin
                mem_we        = 1'b1;
                mem_waddr     = cur_reg;
                mem_re        = 1'b1;
                mem_raddr     = next_slot_reg;
                cur_next      = next_slot_reg;
                res_ok_next   = 1'b1;
                res_slot_next = next_slot_reg;
                res_rd_next   = 1'b1;
                // only one task: the pointer just saved is the one returned
                res_fwd_next  = (next_slot_reg == cur_reg);
            end
        end
    end

    always_comb begin
        if (!res_rd_reg) begin
            res_nsp = '0;
        end else if (res_fwd_reg) begin
            res_nsp = sp_reg;
        end else begin
            res_nsp = rd_data_reg;
        end
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rrts_pkg::ST_IDLE;
            running_reg   <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg         <= rrts_pkg::op_t'(s_tuser);
            sp_reg         <= s_tdata[SP_W-1:0];
            free_found_reg <= pick_free_found;
            free_slot_reg  <= pick_free_slot;
            next_slot_reg  <= pick_next_slot;
        end
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        res_rd_reg   <= res_rd_next;
        res_fwd_reg  <= res_fwd_next;
        if (out_load) begin
            m_ok_reg   <= res_ok_reg;
            m_slot_reg <= SF_W'(res_slot_reg);
            m_nsp_reg  <= res_nsp;
        end
    end

    // pointer store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ptr_mem[mem_waddr] <= sp_reg;
        end
        if (mem_re) begin
            rd_data_reg <= ptr_mem[mem_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = rrts_pkg::M_TDATA_W'({m_nsp_reg, m_slot_reg});

endmodule
